[hdl/sli_pkg.sv]
package sli_pkg;

	// fixed widths of the item fields
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 5;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DELETED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t                    opcode;
		logic signed [VALUE_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		status_t             status;
		logic [POS_W-1:0]    position;
		logic [COUNT_W-1:0]  entry_count;
	} res_item_t;

	// shift commands broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

[hdl/sli_cell.sv]
module sli_cell (
	input  logic                               clk,
	input  sli_pkg::cell_ctl_t                 ctl,
	input  logic signed [sli_pkg::VALUE_W-1:0] value,
	input  logic                               valid,
	input  logic                               left_lt,
	input  logic signed [sli_pkg::VALUE_W-1:0] left_entry,
	input  logic signed [sli_pkg::VALUE_W-1:0] right_entry,
	output logic                               lt,
	output logic                               boundary,
	output logic                               hit,
	output logic signed [sli_pkg::VALUE_W-1:0] entry
);

	logic signed [sli_pkg::VALUE_W-1:0] entry_q;
	logic signed [sli_pkg::VALUE_W-1:0] entry_d;

	// held entry is below the incoming value
	assign lt       = valid && (entry_q < value);
	// first cell that is not below the value
	assign boundary = left_lt && !lt;
	assign hit      = boundary && valid && (entry_q == value);
	assign entry    = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctl.ins && !lt) begin
			entry_d = boundary ? value : left_entry;
		end else if (ctl.del && !lt) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

[hdl/sorted_list_insert_delete.sv]
// Sorted list of signed 32-bit values, kept in ascending order in a row of
// CAPACITY identical cells, duplicates allowed. Each cmd item is an insert
// (placed in front of the first stored value that is greater or equal) or a
// delete (removes the first stored value that is equal). Every item gives
// exactly one res item with the status, the sorted position acted on and
// the count after the operation. A refused insert on a full list reports
// position 0 and count CAPACITY; a delete that finds nothing reports
// position 0 and the unchanged count. Rate: one item per clock while
// cmd_stall is low; each res item is registered. All cells compare
// their entry with the value in parallel in the accept cycle, and each cell
// loads from itself, the value, or its left or right neighbor, so the
// compare plus the neighbor shift set the cycle. The single res register
// decouples the sides: cmd_stall is raised only while a res item is waiting
// and res_stall is high. The list is empty after reset; no clearing pass is
// needed since cells above the count are never looked at.
module sorted_list_insert_delete #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  sli_pkg::cmd_item_t cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output sli_pkg::res_item_t res
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned IDX_W = $clog2(CAPACITY);

	// control
	logic                 accept;
	logic                 full;
	logic                 found;
	sli_pkg::cell_ctl_t   ctl;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	logic [IDX_W-1:0]     pos;
	logic                 res_valid_q;
	sli_pkg::res_item_t   res_q;
	sli_pkg::res_item_t   res_d;

	// cell row wiring
	logic [CAPACITY-1:0]                      cell_valid;
	logic [CAPACITY-1:0]                      cell_lt;
	logic [CAPACITY-1:0]                      cell_boundary;
	logic [CAPACITY-1:0]                      cell_hit;
	logic signed [sli_pkg::VALUE_W-1:0]       cell_entry [CAPACITY];

	// a new item is taken unless a finished one is still held back
	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;

	assign full  = (count_q >= CNT_W'(CAPACITY));
	assign found = |cell_hit;

	assign ctl.ins = accept && (cmd.opcode == sli_pkg::OP_INSERT) && !full;
	assign ctl.del = accept && (cmd.opcode == sli_pkg::OP_DELETE) && found;

	// the row of cells: each one sees its neighbors' entries and its left neighbor's compare flag
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                               left_lt;
		logic signed [sli_pkg::VALUE_W-1:0] left_entry;
		logic signed [sli_pkg::VALUE_W-1:0] right_entry;

		assign cell_valid[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			// nothing to the left, so treat it as below the value
			assign left_lt    = 1'b1;
			assign left_entry = cmd.value;
		end else begin : g_inner
			assign left_lt    = cell_lt[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			// past the end the content is never read
			assign right_entry = cell_entry[i];
		end else begin : g_body
			assign right_entry = cell_entry[i+1];
		end

		sli_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.value       (cmd.value),
			.valid       (cell_valid[i]),
			.left_lt     (left_lt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.lt          (cell_lt[i]),
			.boundary    (cell_boundary[i]),
			.hit         (cell_hit[i]),
			.entry       (cell_entry[i])
		);
	end

	// encode the one-hot boundary into the sorted position
	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_boundary[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

	// next count and result item
	always_comb begin
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.del) begin
			count_d = count_q - CNT_W'(1);
		end

		res_d.entry_count = sli_pkg::COUNT_W'(32'(count_d));
		res_d.position    = '0;
		case (cmd.opcode)
			sli_pkg::OP_INSERT: begin
				if (full) begin
					res_d.status = sli_pkg::ST_FULL;
				end else begin
					res_d.status   = sli_pkg::ST_INSERTED;
					res_d.position = sli_pkg::POS_W'(32'(pos));
				end
			end
			sli_pkg::OP_DELETE: begin
				if (found) begin
					res_d.status   = sli_pkg::ST_DELETED;
					res_d.position = sli_pkg::POS_W'(32'(pos));
				end else begin
					res_d.status = sli_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				res_d.status = sli_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only when an item is taken
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	// count stays within the row
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// sorted order: a cell below the value implies every cell to its left is too
	a_lt_thermometer: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_lt & ~{cell_lt[CAPACITY-2:0], 1'b1}) == '0)
		else $error("cell compare flags not contiguous");

	a_boundary_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_boundary))
		else $error("more than one insertion point");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.del |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("delete did not shrink the count");
`endif

endmodule

[dv/sorted_list_checker.sv]
module sorted_list_checker #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  sli_pkg::cmd_item_t cmd,
	input  logic               res_valid,
	input  logic               res_stall,
	input  sli_pkg::res_item_t res,
	output int                 fail_count,
	output int                 pending,
	output int                 checked,
	output int                 full_hits,
	output int                 miss_hits,
	output int                 peak_fill
);

	// shadow copy of the list, ascending signed order
	logic signed [sli_pkg::VALUE_W-1:0] list_vals[$];
	sli_pkg::res_item_t                 awaited_res[$];
	sli_pkg::res_item_t                 want;

	// apply one operation to the shadow list and return the result it gives
	function automatic sli_pkg::res_item_t apply_op(sli_pkg::cmd_item_t c);
		sli_pkg::res_item_t r;
		int unsigned        slot;
		slot = 0;
		while (slot < list_vals.size() && list_vals[slot] < c.value)
			slot++;
		r.position = '0;
		if (c.opcode == sli_pkg::OP_INSERT) begin
			if (list_vals.size() >= CAPACITY) begin
				r.status = sli_pkg::ST_FULL;
			end else begin
				list_vals.insert(slot, c.value);
				r.status   = sli_pkg::ST_INSERTED;
				r.position = sli_pkg::POS_W'(slot);
			end
		end else if (slot < list_vals.size() && list_vals[slot] == c.value) begin
			list_vals.delete(slot);
			r.status   = sli_pkg::ST_DELETED;
			r.position = sli_pkg::POS_W'(slot);
		end else begin
			r.status = sli_pkg::ST_NOT_FOUND;
		end
		r.entry_count = sli_pkg::COUNT_W'(list_vals.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_vals.delete();
			awaited_res.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
			full_hits  = 0;
			miss_hits  = 0;
			peak_fill  = 0;
		end else begin
			// result side first: it always belongs to an earlier item
			if (res_valid && !res_stall) begin
				if (awaited_res.size() == 0) begin
					fail_count++;
					$display("%0t: res item with nothing awaited, got %p", $time, res);
				end else begin
					want = awaited_res.pop_front();
					checked++;
					if (res.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %s got %s", $time,
							want.status.name(), res.status.name());
					end
					if (res.position !== want.position) begin
						fail_count++;
						$display("%0t: position expected %0d got %0d", $time,
							want.position, res.position);
					end
					if (res.entry_count !== want.entry_count) begin
						fail_count++;
						$display("%0t: entry_count expected %0d got %0d", $time,
							want.entry_count, res.entry_count);
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				want = apply_op(cmd);
				awaited_res.push_back(want);
				if (want.status == sli_pkg::ST_FULL)
					full_hits++;
				if (want.status == sli_pkg::ST_NOT_FOUND)
					miss_hits++;
				if (list_vals.size() > peak_fill)
					peak_fill = list_vals.size();
			end
			pending = awaited_res.size();
		end
	end

endmodule

[dv/sorted_list_insert_delete_test.sv]
module sorted_list_insert_delete_test;

	localparam int unsigned CAPACITY   = 16;
	localparam int          RAND_ITEMS = 400;
	localparam logic signed [sli_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [sli_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	sli_pkg::cmd_item_t cmd;
	logic               res_valid;
	logic               res_stall;
	sli_pkg::res_item_t res;

	int fail_count;
	int pending;
	int checked;
	int full_hits;
	int miss_hits;
	int peak_fill;

	// sender burst bookkeeping
	int unsigned burst_left;

	// recently inserted values, so that many deletes actually hit
	logic signed [sli_pkg::VALUE_W-1:0] recent_vals[32];
	int unsigned                        recent_n;

	// receiver stall pattern state
	int unsigned stall_mode;
	int unsigned stall_span;
	int unsigned stall_tick;

	sorted_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// watches both channels, keeps the shadow list and scores every result
	sorted_list_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked),
		.full_hits (full_hits),
		.miss_hits (miss_hits),
		.peak_fill (peak_fill)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the handshake locks up
	initial begin
		#3_000_000;
		$display("%0t: timeout, %0d results still awaited", $time, pending);
		$display("== FAIL ==");
		$finish;
	end

	// receiver: stall pattern whose mode is picked anew at random
	// mode 0 never stalls, 1 stalls now and then, 2 is a fixed periodic
	// pattern, 3 stalls most of the time
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(8, 80);
		end else begin
			stall_span <= stall_span - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 2) == 0);
			2: res_stall <= ((stall_tick % 5) < 2);
			default: res_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	// present one item at a falling edge and hold it until it is taken;
	// between bursts the valid usually drops for a random pause
	task automatic send_item(input sli_pkg::cmd_item_t c);
		int unsigned pause;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (pause != 0) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
				repeat (pause - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic send_op(input sli_pkg::opcode_t op,
		input logic signed [sli_pkg::VALUE_W-1:0] v);
		sli_pkg::cmd_item_t c;
		c.opcode = op;
		c.value  = v;
		send_item(c);
		if (op == sli_pkg::OP_INSERT) begin
			recent_vals[recent_n % 32] = v;
			recent_n++;
		end
	endtask

	// random value: extremes, a narrow band around zero for duplicates,
	// or any 32-bit word
	function automatic logic signed [sli_pkg::VALUE_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return VALUE_MIN;
		else if (sel == 1)
			return VALUE_MAX;
		else if (sel < 6)
			return int'($urandom_range(0, 20)) - 10;
		else
			return $urandom;
	endfunction

	initial begin
		int                                 k;
		int unsigned                        lean;
		sli_pkg::opcode_t                   op;
		logic signed [sli_pkg::VALUE_W-1:0] v;

		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		cmd        = '0;
		res_stall  = 1'b0;
		burst_left = 0;
		recent_n   = 0;
		stall_mode = 0;
		stall_span = 0;
		stall_tick = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part
		// delete on an empty list finds nothing
		send_op(sli_pkg::OP_DELETE, 32'sd5);
		// removing the only entry empties the list again
		send_op(sli_pkg::OP_INSERT, 32'sd42);
		send_op(sli_pkg::OP_DELETE, 32'sd42);
		// extremes, a duplicate, and values on both sides of zero
		send_op(sli_pkg::OP_INSERT, VALUE_MIN);
		send_op(sli_pkg::OP_INSERT, VALUE_MAX);
		send_op(sli_pkg::OP_INSERT, 32'sd0);
		send_op(sli_pkg::OP_INSERT, -32'sd1);
		send_op(sli_pkg::OP_INSERT, 32'sd0);
		send_op(sli_pkg::OP_INSERT, 32'sd1);
		// miss, then removal of the last entry, the first, one of a duplicate pair
		send_op(sli_pkg::OP_DELETE, 32'sd7);
		send_op(sli_pkg::OP_DELETE, VALUE_MAX);
		send_op(sli_pkg::OP_DELETE, VALUE_MIN);
		send_op(sli_pkg::OP_DELETE, 32'sd0);
		// fill up to capacity with a mix of orders
		for (k = 0; k < CAPACITY - 3; k++)
			send_op(sli_pkg::OP_INSERT, ((k * 7) % 13 - 6) * 1000);
		// refused insert on a full list, miss on a full list, then a hit
		send_op(sli_pkg::OP_INSERT, 32'sd3);
		send_op(sli_pkg::OP_DELETE, 32'sd12345);
		send_op(sli_pkg::OP_DELETE, 32'sd1);

		// random part in phases that lean toward filling, draining or
		// neither, so the count sweeps between empty and full many times
		lean = 0;
		for (k = 0; k < RAND_ITEMS; k++) begin
			if (k % 40 == 0)
				lean = $urandom_range(0, 2);
			case (lean)
				0: op = ($urandom_range(0, 3) != 0) ? sli_pkg::OP_INSERT : sli_pkg::OP_DELETE;
				1: op = ($urandom_range(0, 3) == 0) ? sli_pkg::OP_INSERT : sli_pkg::OP_DELETE;
				default: op = ($urandom_range(0, 1) == 0) ? sli_pkg::OP_INSERT
					: sli_pkg::OP_DELETE;
			endcase
			// most deletes aim at something inserted not long ago
			if (op == sli_pkg::OP_DELETE && recent_n != 0 && $urandom_range(0, 3) != 0)
				v = recent_vals[$urandom_range(0, (recent_n < 32 ? recent_n : 32) - 1)];
			else
				v = pick_value();
			send_op(op, v);
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		// extra clocks catch any stray result
		repeat (4) @(posedge clk);

		$display("%0d results scored, peak fill %0d of %0d", checked, peak_fill, CAPACITY);
		$display("%0d inserts refused on a full list, %0d deletes with no match",
			full_hits, miss_hits);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
